// File: rtl/core/tsbd_pkg.sv
package tsbd_pkg;

  localparam int COORD_W = 32;
  localparam int TRIG_W  = 16;
  localparam int PROD_W  = 48;
  localparam int SUM_W   = 63;
  localparam int AMP_W   = 32;
  localparam int MAG_W   = 33;
  localparam int CNT_W   = 15;
  localparam int LANES   = 3;
  localparam int SUMS    = 6;

  localparam logic [0:0] REG_PHASE_START = 1'b0;
  localparam logic [0:0] REG_PHASE_STEP  = 1'b1;

  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic signed [AMP_W-1:0] amp_t;

  function automatic logic [15:0] sine_entry(input int n, input int k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] s;
    logic signed [63:0] v;
    x = (64'd1686629713 * 64'(k) + 64'(n / 2)) / 64'(n);
    x2 = (x * x) >> 30;
    term = x;
    s = $signed(x);
    for (int i = 1; i <= 8; i++) begin
      term = ((term * x2) >> 30) / 64'((2 * i) * (2 * i + 1));
      if ((i % 2) == 1) s = s - $signed(term);
      else s = s + $signed(term);
    end
    if (s < 0) s = 0;
    v = (s + 64'sd16384) >>> 15;
    if (v > 64'sd32767) v = 64'sd32767;
    return v[15:0];
  endfunction

endpackage

// File: rtl/core/three_axis_single_bin_dft_unit.sv
// A sample that does not close a run is only accumulated; a run streams one sample per cycle.
// A closing sample starts the divide and root pass: 6 x 62 restoring divide steps,
// 6 squaring steps and 34 root steps, after which the result register is loaded.
// No sample is taken during the pass; after it the next run streams while the result waits,
// and only its closing sample is held until the result is delivered.
// Reset (rst_n low, synchronous) clears the phase and run state and the result valid.
module three_axis_single_bin_dft_unit #(
  parameter int MAX_SAMPLES        = 16384,
  parameter int SINE_TABLE_ENTRIES = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [0:0]                          cfg_index,
  input  logic [31:0]                         cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [tsbd_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [tsbd_pkg::COORD_W-1:0] in_coord_y,
  input  logic signed [tsbd_pkg::COORD_W-1:0] in_coord_z,
  input  logic                                in_last_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [31:0]                  out_amp_x_cos,
  output logic signed [31:0]                  out_amp_x_sin,
  output logic signed [31:0]                  out_amp_y_cos,
  output logic signed [31:0]                  out_amp_y_sin,
  output logic signed [31:0]                  out_amp_z_cos,
  output logic signed [31:0]                  out_amp_z_sin,
  output logic [tsbd_pkg::MAG_W-1:0]          out_magnitude,
  output logic [tsbd_pkg::CNT_W-1:0]          out_sample_count
);
  import tsbd_pkg::*;

  localparam int IW = $clog2(SINE_TABLE_ENTRIES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);

  function automatic logic [15:0] build_one(int k);
    return sine_entry(SINE_TABLE_ENTRIES, k);
  endfunction

  typedef logic [15:0] rom_t [SINE_TABLE_ENTRIES+1];
  function automatic rom_t build();
    rom_t r;
    for (int k = 0; k <= SINE_TABLE_ENTRIES; k++) r[k] = build_one(k);
    return r;
  endfunction

  localparam logic [15:0] ROM [SINE_TABLE_ENTRIES+1] = build();

  logic [31:0] start_r, step_r, acc_r;
  logic [CW-1:0] cnt_r;
  logic busy_r, out_valid_r, clr_r;
  logic [CNT_W+1:0] div_cnt_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic [31:0] ph, phc;
  logic signed [TRIG_W-1:0] sn, cs;
  logic take, close;
  sum_t sums [SUMS];
  amp_t amps [SUMS];
  logic done;
  logic [MAG_W-1:0] mag;
  amp_t amp_r [SUMS];
  logic [MAG_W-1:0] mag_r;

  function automatic logic signed [TRIG_W-1:0] trig(input logic [31:0] p);
    logic [IW:0] i;
    logic [15:0] v;
    i = (IW+1)'(({34'd0, p[29:0]} * 64'(SINE_TABLE_ENTRIES)) >> 30);
    v = p[30] ? ROM[(IW+1)'(SINE_TABLE_ENTRIES) - i] : ROM[i];
    return p[31] ? -$signed(v) : $signed(v);
  endfunction

  assign ph = start_r + acc_r;
  assign phc = ph + 32'h4000_0000;
  assign sn = trig(ph);
  assign cs = trig(phc);
  assign in_ready = !busy_r && !(out_valid_r && close);
  assign take = in_valid && in_ready;
  assign close = in_last_sample || (cnt_r + CW'(1) >= CW'(MAX_SAMPLES));

  tsbd_lane u_lx (.clk, .clr(clr_r), .en(take), .coord(in_coord_x), .cos_v(cs), .sin_v(sn),
                  .sum_cos(sums[0]), .sum_sin(sums[1]));
  tsbd_lane u_ly (.clk, .clr(clr_r), .en(take), .coord(in_coord_y), .cos_v(cs), .sin_v(sn),
                  .sum_cos(sums[2]), .sum_sin(sums[3]));
  tsbd_lane u_lz (.clk, .clr(clr_r), .en(take), .coord(in_coord_z), .cos_v(cs), .sin_v(sn),
                  .sum_cos(sums[4]), .sum_sin(sums[5]));

  logic start_m_r;
  tsbd_merge u_merge (.clk, .rst_n, .start(start_m_r), .sums, .count(div_cnt_r),
                      .done, .amps, .mag);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      step_r <= '0;
      acc_r <= '0;
      cnt_r <= '0;
      busy_r <= 1'b0;
      out_valid_r <= 1'b0;
      clr_r <= 1'b1;
      start_m_r <= 1'b0;
    end else begin
      clr_r <= 1'b0;
      start_m_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_PHASE_START: start_r <= cfg_data;
          REG_PHASE_STEP:  step_r <= cfg_data;
          default: ;
        endcase
      end
      if (take) begin
        if (close) begin
          busy_r <= 1'b1;
          start_m_r <= 1'b1;
          div_cnt_r <= (CNT_W+2)'(cnt_r + CW'(1));
          out_cnt_r <= CNT_W'(cnt_r + CW'(1));
          acc_r <= '0;
          cnt_r <= '0;
        end else begin
          acc_r <= acc_r + step_r;
          cnt_r <= cnt_r + CW'(1);
        end
      end
      if (done) begin
        busy_r <= 1'b0;
        out_valid_r <= 1'b1;
        clr_r <= 1'b1;
        amp_r <= amps;
        mag_r <= mag;
      end
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_amp_x_cos = amp_r[0];
  assign out_amp_x_sin = amp_r[1];
  assign out_amp_y_cos = amp_r[2];
  assign out_amp_y_sin = amp_r[3];
  assign out_amp_z_cos = amp_r[4];
  assign out_amp_z_sin = amp_r[5];
  assign out_magnitude = mag_r;
  assign out_sample_count = out_cnt_r;
endmodule

// File: rtl/core/tsbd_lane.sv
module tsbd_lane (
  input  logic                                 clk,
  input  logic                                 clr,
  input  logic                                 en,
  input  logic signed [tsbd_pkg::COORD_W-1:0]  coord,
  input  logic signed [tsbd_pkg::TRIG_W-1:0]   cos_v,
  input  logic signed [tsbd_pkg::TRIG_W-1:0]   sin_v,
  output tsbd_pkg::sum_t                       sum_cos,
  output tsbd_pkg::sum_t                       sum_sin
);
  import tsbd_pkg::*;

  sum_t sum_cos_r, sum_cos_nxt, sum_sin_r, sum_sin_nxt;
  logic signed [PROD_W-1:0] pc, ps;

  assign pc = PROD_W'(coord) * PROD_W'(cos_v);
  assign ps = PROD_W'(coord) * PROD_W'(sin_v);

  always_comb begin
    sum_cos_nxt = sum_cos_r;
    sum_sin_nxt = sum_sin_r;
    if (clr) begin
      sum_cos_nxt = '0;
      sum_sin_nxt = '0;
    end
    if (en) begin
      sum_cos_nxt = sum_cos_nxt + SUM_W'(pc);
      sum_sin_nxt = sum_sin_nxt + SUM_W'(ps);
    end
  end

  always_ff @(posedge clk) begin
    sum_cos_r <= sum_cos_nxt;
    sum_sin_r <= sum_sin_nxt;
  end

  assign sum_cos = sum_cos_r;
  assign sum_sin = sum_sin_r;
endmodule

// File: rtl/core/tsbd_merge.sv
module tsbd_merge (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  tsbd_pkg::sum_t                       sums [tsbd_pkg::SUMS],
  input  logic [tsbd_pkg::CNT_W+1:0]           count,
  output logic                                 done,
  output tsbd_pkg::amp_t                       amps [tsbd_pkg::SUMS],
  output logic [tsbd_pkg::MAG_W-1:0]           mag
);
  import tsbd_pkg::*;

  localparam int DVD_W = SUM_W - 1;
  localparam int DVS_W = CNT_W + 2 + 15;
  localparam int ACC_W = 68;
  localparam int RT_W  = 34;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_SQ   = 3'd2;
  localparam logic [2:0] S_ROOT = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_r;
  logic [2:0] idx_r;
  logic [6:0] bit_r;
  logic [DVD_W-1:0] rem_r, quo_r;
  logic [DVS_W-1:0] dvs_r;
  logic neg_r;
  logic [ACC_W-1:0] acc_r, rad_r;
  logic [RT_W-1:0] root_r;
  logic [ACC_W-1:0] rem_sh, trial, rq;
  logic [DVD_W:0] rem2;
  amp_t amps_r [SUMS];
  logic [63:0] sq;

  assign rem2 = {rem_r, quo_r[DVD_W-1]};
  assign sq = 64'(amps_r[idx_r]) * 64'(amps_r[idx_r]);
  assign trial = {root_r, 2'b01} ;
  assign rem_sh = {rad_r[ACC_W-3:0], acc_r[ACC_W-1:ACC_W-2]};
  assign rq = rem_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_DIV;
            idx_r <= '0;
            bit_r <= 7'(DVD_W);
            dvs_r <= DVS_W'(count) << 15;
            neg_r <= sums[0][SUM_W-1];
            quo_r <= sums[0][SUM_W-1] ? DVD_W'(-sums[0]) : DVD_W'(sums[0]);
            rem_r <= '0;
          end
        end
        S_DIV: begin
          if ({1'b0, rem2} >= (DVD_W+2)'(dvs_r)) begin
            rem_r <= DVD_W'(rem2 - (DVD_W+1)'(dvs_r));
            quo_r <= {quo_r[DVD_W-2:0], 1'b1};
          end else begin
            rem_r <= DVD_W'(rem2);
            quo_r <= {quo_r[DVD_W-2:0], 1'b0};
          end
          bit_r <= bit_r - 7'd1;
          if (bit_r == 7'd1) begin
            amps_r[idx_r] <= neg_r ? -AMP_W'(quo_r[DVD_W-2:0] << 1 |
                             DVD_W'({1'b0, rem2} >= (DVD_W+2)'(dvs_r)))
                           : AMP_W'(quo_r[DVD_W-2:0] << 1 |
                             DVD_W'({1'b0, rem2} >= (DVD_W+2)'(dvs_r)));
            if (idx_r == 3'(SUMS - 1)) begin
              state_r <= S_SQ;
              idx_r <= '0;
              acc_r <= '0;
            end else begin
              idx_r <= idx_r + 3'd1;
              bit_r <= 7'(DVD_W);
              neg_r <= sums[idx_r + 3'd1][SUM_W-1];
              quo_r <= sums[idx_r + 3'd1][SUM_W-1] ? DVD_W'(-sums[idx_r + 3'd1])
                                                    : DVD_W'(sums[idx_r + 3'd1]);
              rem_r <= '0;
            end
          end
        end
        S_SQ: begin
          acc_r <= acc_r + ACC_W'(sq);
          if (idx_r == 3'(SUMS - 1)) begin
            state_r <= S_ROOT;
            bit_r <= 7'(RT_W);
            rad_r <= '0;
            root_r <= '0;
          end else begin
            idx_r <= idx_r + 3'd1;
          end
        end
        S_ROOT: begin
          acc_r <= acc_r << 2;
          if (rq >= ACC_W'(trial)) begin
            rad_r <= rq - ACC_W'(trial);
            root_r <= {root_r[RT_W-2:0], 1'b1};
          end else begin
            rad_r <= rq;
            root_r <= {root_r[RT_W-2:0], 1'b0};
          end
          bit_r <= bit_r - 7'd1;
          if (bit_r == 7'd1) state_r <= S_DONE;
        end
        S_DONE: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign done = (state_r == S_DONE);
  assign amps = amps_r;
  assign mag = root_r[MAG_W-1:0];
endmodule
